/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the edge zone walker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define EZRW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define EZRW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hw/rtl/ezrw_pkg.sv */
// Types and constants shared by the edge zone rectangle walker.
`timescale 1ns / 1ps
package ezrw_pkg;

  localparam int unsigned AREA_W     = 8;
  localparam int unsigned ASPECT_W   = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned EDGE_W     = 2;
  localparam int unsigned PHASE_W    = 2;
  // Side count division: numerator 512*N + 512 + A, quotient below 2^8.
  localparam int unsigned SIDE_NUM_W = 18;
  localparam int unsigned SIDE_Q_W   = 8;
  localparam int unsigned DEN_W      = 13;
  // Signed top count N - 2*S.
  localparam int unsigned TOP_T_W    = 10;

  localparam logic [CFG_IDX_W-1:0] REG_AREA_COUNT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ASPECT_RATIO = 1'd1;

  localparam logic [AREA_W-1:0]   AREA_RESET   = 8'd10;
  localparam logic [ASPECT_W-1:0] ASPECT_RESET = 11'd455;

  localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_RIGHT = 2'd1;
  localparam logic [PHASE_W-1:0] PH_TOP   = 2'd2;
  localparam logic [PHASE_W-1:0] PH_LEFT  = 2'd3;

  typedef enum logic [2:0] {
    OP_FIRST,
    OP_TOP,
    OP_LEFT,
    OP_STEP_LO,
    OP_STEP_HI
  } rec_op_e;

  typedef struct packed {
    logic    valid;
    rec_op_e op;
  } rec_cmd_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               v_near;
    logic               h_near;
  } rec_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hw/rtl/ezrw_div.sv */
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ezrw_div #(
  parameter int unsigned NW   = 18,
  parameter int unsigned DENW = 13,
  parameter int unsigned CNTW = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DENW-1:0]     rem_i,
  input  logic [NW-1:0]       num_i,
  input  logic [DENW-1:0]     den_i,
  input  logic [CNTW-1:0]     count_i,
  output logic [NW-1:0]       quot_o,
  output ezrw_pkg::div_stat_t stat_o
);
  import ezrw_pkg::*;

  logic [DENW-1:0] rem_q;
  logic [NW-1:0]   num_q;
  logic [DENW-1:0] den_q;
  logic [NW-1:0]   quot_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [DENW:0]   trial;
  logic [DENW:0]   diff;
  logic            fits;

  assign trial = {rem_q, num_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= count_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_i;
      num_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[DENW-1:0] : trial[DENW-1:0];
      num_q  <= {num_q[NW-2:0], 1'b0};
      quot_q <= {quot_q[NW-2:0], fits};
    end
  end

  assign quot_o      = quot_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

/* hw/rtl/ezrw_rect.sv */
// Zone rectangle state with the shared clamped add/subtract unit.
`timescale 1ns / 1ps
module ezrw_rect #(
  parameter int unsigned COORD_FRAC_BITS = 16,
  parameter int unsigned CW              = COORD_FRAC_BITS + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ezrw_pkg::rec_cmd_t  cmd_i,
  input  logic [CW-1:0]       len_i,
  output ezrw_pkg::rec_stat_t stat_o,
  output logic [CW-1:0]       h_start_o,
  output logic [CW-1:0]       h_end_o,
  output logic [CW-1:0]       v_start_o,
  output logic [CW-1:0]       v_end_o
);
  import ezrw_pkg::*;

  localparam int unsigned ONE_I   = 1 << COORD_FRAC_BITS;
  localparam int unsigned THICK_I = (15 * ONE_I + 50) / 100;
  localparam int unsigned TOL_I   = (ONE_I + 50) / 100;
  localparam logic [CW-1:0] ONE   = CW'(ONE_I);
  localparam logic [CW-1:0] THICK = CW'(THICK_I);
  localparam logic [CW-1:0] TOL   = CW'(TOL_I);

  logic [PHASE_W-1:0] phase_q;
  logic [CW-1:0]      hs_q, he_q, vs_q, ve_q;
  logic [CW-1:0]      w_q, h_q;

  logic          hi_sel;
  logic          do_add;
  logic [CW-1:0] op_a, op_b;
  logic [CW:0]   op_b_x;
  logic [CW:0]   sum;
  logic [CW-1:0] res;

  // Top edge moves left along h, the side edges move along v.
  always_comb begin
    hi_sel = (cmd_i.op == OP_STEP_HI);
    do_add = (phase_q == PH_LEFT);
    if (phase_q == PH_TOP) begin
      op_a = hi_sel ? he_q : hs_q;
      op_b = w_q;
    end else begin
      op_a = hi_sel ? ve_q : vs_q;
      op_b = h_q;
    end
    op_b_x = do_add ? {1'b0, op_b} : ~{1'b0, op_b};
    sum    = {1'b0, op_a} + op_b_x + {{CW{1'b0}}, !do_add};
    if (do_add) begin
      res = (sum > {1'b0, ONE}) ? ONE : sum[CW-1:0];
    end else begin
      res = sum[CW] ? '0 : sum[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hs_q    <= '0;
      he_q    <= '0;
      vs_q    <= '0;
      ve_q    <= '0;
      w_q     <= '0;
      h_q     <= '0;
    end else if (cmd_i.valid) begin
      unique case (cmd_i.op)
        OP_FIRST: begin
          phase_q <= PH_RIGHT;
          w_q     <= THICK;
          h_q     <= len_i;
          hs_q    <= ONE - THICK;
          he_q    <= ONE;
          vs_q    <= ONE - len_i;
          ve_q    <= ONE;
        end
        OP_TOP: begin
          phase_q <= PH_TOP;
          w_q     <= len_i;
          h_q     <= THICK;
          hs_q    <= ONE - len_i;
          he_q    <= ONE;
          vs_q    <= '0;
          ve_q    <= THICK;
        end
        OP_LEFT: begin
          phase_q <= PH_LEFT;
          w_q     <= THICK;
          h_q     <= len_i;
          hs_q    <= '0;
          he_q    <= THICK;
          vs_q    <= '0;
          ve_q    <= len_i;
        end
        OP_STEP_LO: begin
          if (phase_q == PH_TOP) begin
            hs_q <= res;
          end else begin
            vs_q <= res;
          end
        end
        OP_STEP_HI: begin
          if (phase_q == PH_TOP) begin
            he_q <= res;
          end else begin
            ve_q <= res;
          end
        end
        default: ;
      endcase
    end
  end

  assign stat_o.phase  = phase_q;
  assign stat_o.v_near = (vs_q <= TOL);
  assign stat_o.h_near = (hs_q <= TOL);
  assign h_start_o     = hs_q;
  assign h_end_o       = he_q;
  assign v_start_o     = vs_q;
  assign v_end_o       = ve_q;

endmodule

/* hw/rtl/edge_zone_rectangle_walker_top.sv */
// Top level of the edge zone rectangle walker: sequencer, registers, output stage.
// Sequence: a step along the current edge moves the zone's low end, then its high end, and
// stages the zone from the done state; a new edge (first, top or left zone) runs the serial
// divider for the side count (8 quotient bits), then for the zone length (COORD_FRAC_BITS + 1 bits).
// Requests: one at a time; ready returns with the staged result, and the done state holds
// until the output stage is free.
// Reset: asynchronous, active low; the walk returns to not started, registers to 10 / 455.
`timescale 1ns / 1ps
module edge_zone_rectangle_walker_top #(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [ezrw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ezrw_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                restart_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [COORD_FRAC_BITS:0]            h_start_o,
  output logic [COORD_FRAC_BITS:0]            h_end_o,
  output logic [COORD_FRAC_BITS:0]            v_start_o,
  output logic [COORD_FRAC_BITS:0]            v_end_o,
  output logic [ezrw_pkg::EDGE_W-1:0]         edge_res_o
);
  import ezrw_pkg::*;

`include "assert_macros.svh"

  localparam int unsigned CW   = COORD_FRAC_BITS + 1;
  localparam int unsigned DW   = (CW > SIDE_NUM_W) ? CW : SIDE_NUM_W;
  localparam int unsigned CNTW = $clog2(DW + 1);
  localparam logic [CW-1:0] ONE = CW'(1 << COORD_FRAC_BITS);

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SIDE = 3'd1;
  localparam logic [2:0] ST_LEN  = 3'd2;
  localparam logic [2:0] ST_STEP = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]          state_q, state_d;
  rec_op_e             load_op_q, load_op_d;
  logic [AREA_W-1:0]   area_q;
  logic [ASPECT_W-1:0] aspect_q;

  logic                accept;
  rec_op_e             pick;
  rec_cmd_t            rec_cmd;
  rec_stat_t           rec_stat;

  logic                div_start;
  logic [DEN_W-1:0]    div_rem;
  logic [DW-1:0]       div_num;
  logic [DEN_W-1:0]    div_den;
  logic [CNTW-1:0]     div_cnt;
  logic [DW-1:0]       div_quot;
  div_stat_t           div_stat;

  logic [SIDE_NUM_W-1:0] side_num;
  logic [DEN_W-1:0]      side_den;
  logic [SIDE_Q_W-1:0]   side_sat;
  logic [TOP_T_W-1:0]    top_t;
  logic [SIDE_Q_W-1:0]   zone_cnt;
  logic [CW-1:0]         len_num;

  logic [CW-1:0] rect_hs, rect_he, rect_vs, rect_ve;

  logic                out_valid_q;
  logic [CW-1:0]       hs_out_q, he_out_q, vs_out_q, ve_out_q;
  logic [EDGE_W-1:0]   edge_out_q;
  logic                out_load;

  // ---------------------------------------------------------------------------
  // Configuration registers: plain writes, unknown indexes cannot occur.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q   <= AREA_RESET;
      aspect_q <= ASPECT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AREA_COUNT:   area_q   <= cfg_wdata_i[AREA_W-1:0];
        REG_ASPECT_RATIO: aspect_q <= cfg_wdata_i[ASPECT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request decode: restart or a fresh walk loads the first right-edge zone,
  // reaching the end of the right or top edge loads the next edge, otherwise step in place.
  // ---------------------------------------------------------------------------
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (restart_i || rec_stat.phase == PH_IDLE) begin
      pick = OP_FIRST;
    end else if (rec_stat.phase == PH_RIGHT && rec_stat.v_near) begin
      pick = OP_TOP;
    end else if (rec_stat.phase == PH_TOP && rec_stat.h_near) begin
      pick = OP_LEFT;
    end else begin
      pick = OP_STEP_LO;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider operands. Side count: round(256 N / (512 + A)), quotient fits in
  // 8 bits, so preload the remainder with the numerator from bit 8 up and run
  // only 8 iterations. Zone length: (ONE + C/2) / C over CW bits.
  // ---------------------------------------------------------------------------
  assign side_num = {1'b0, area_q, 9'd0} + SIDE_NUM_W'(512) + SIDE_NUM_W'(aspect_q);
  assign side_den = DEN_W'(1024) + DEN_W'({aspect_q, 1'b0});

  always_comb begin
    side_sat = (div_quot[SIDE_Q_W-1:0] == '0) ? SIDE_Q_W'(1) : div_quot[SIDE_Q_W-1:0];
    top_t    = TOP_T_W'(area_q) - TOP_T_W'({side_sat, 1'b0});
    if (load_op_q == OP_TOP) begin
      // saturate a top count below one to one
      zone_cnt = (top_t[TOP_T_W-1] || top_t == '0) ? SIDE_Q_W'(1) : top_t[SIDE_Q_W-1:0];
    end else begin
      zone_cnt = side_sat;
    end
    len_num = ONE + CW'(zone_cnt[SIDE_Q_W-1:1]);
  end

  always_comb begin
    div_start = 1'b0;
    div_rem   = DEN_W'(side_num[SIDE_NUM_W-1:SIDE_Q_W]);
    div_num   = DW'(side_num[SIDE_Q_W-1:0]) << (DW - SIDE_Q_W);
    div_den   = side_den;
    div_cnt   = CNTW'(SIDE_Q_W);
    if (state_q == ST_SIDE) begin
      div_start = div_stat.done;
      div_rem   = '0;
      div_num   = DW'(len_num) << (DW - CW);
      div_den   = DEN_W'(zone_cnt);
      div_cnt   = CNTW'(CW);
    end else begin
      div_start = accept && (pick != OP_STEP_LO);
    end
  end

  ezrw_div #(
    .NW   (DW),
    .DENW (DEN_W),
    .CNTW (CNTW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .num_i   (div_num),
    .den_i   (div_den),
    .count_i (div_cnt),
    .quot_o  (div_quot),
    .stat_o  (div_stat)
  );

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    load_op_d   = load_op_q;
    rec_cmd     = '{valid: 1'b0, op: OP_STEP_LO};
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          load_op_d = pick;
          if (pick == OP_STEP_LO) begin
            rec_cmd = '{valid: 1'b1, op: OP_STEP_LO};
            state_d = ST_STEP;
          end else begin
            state_d = ST_SIDE;
          end
        end
      end
      ST_SIDE: begin
        if (div_stat.done) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        if (div_stat.done) begin
          rec_cmd = '{valid: 1'b1, op: load_op_q};
          state_d = ST_DONE;
        end
      end
      ST_STEP: begin
        rec_cmd = '{valid: 1'b1, op: OP_STEP_HI};
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output stage is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      load_op_q <= OP_FIRST;
    end else begin
      state_q   <= state_d;
      load_op_q <= load_op_d;
    end
  end

  ezrw_rect #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .CW              (CW)
  ) u_rect (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (rec_cmd),
    .len_i     (div_quot[CW-1:0]),
    .stat_o    (rec_stat),
    .h_start_o (rect_hs),
    .h_end_o   (rect_he),
    .v_start_o (rect_vs),
    .v_end_o   (rect_ve)
  );

  // ---------------------------------------------------------------------------
  // Output stage: parts the result from the walker so a new request can be
  // taken while this one waits.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      hs_out_q   <= rect_hs;
      he_out_q   <= rect_he;
      vs_out_q   <= rect_vs;
      ve_out_q   <= rect_ve;
      edge_out_q <= EDGE_W'(rec_stat.phase - PH_RIGHT);
    end
  end

  assign out_valid_o = out_valid_q;
  assign h_start_o   = hs_out_q;
  assign h_end_o     = he_out_q;
  assign v_start_o   = vs_out_q;
  assign v_end_o     = ve_out_q;
  assign edge_res_o  = edge_out_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `EZRW_ASSERT(a_busy_after_req, accept |=> !in_ready_o, "request taken while busy")
  `EZRW_ASSERT(a_walk_stays, rec_stat.phase != PH_IDLE |=> rec_stat.phase != PH_IDLE, "walk lost")
  `EZRW_ASSERT_ALWAYS(a_div_free, div_start |-> !div_stat.busy, "divider restarted mid-run")
  `EZRW_ASSERT(a_step_pair, (rec_cmd.valid && rec_cmd.op == OP_STEP_LO) |=> (rec_cmd.valid && rec_cmd.op == OP_STEP_HI), "step split")

endmodule
